// ----- src/nearest_point_view_cone_select_assert.svh -----
// assertion macros for the nearest point view cone select block
// used by the checker module only
`ifndef NEAREST_POINT_VIEW_CONE_SELECT_ASSERT_SVH
`define NEAREST_POINT_VIEW_CONE_SELECT_ASSERT_SVH
// property on a clock with synchronous active-low reset as disable
`define NPVC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same with no disable, for reset behavior
`define NPVC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/npvc_pkg.sv -----
// package for the nearest point view cone select block
// types, register indexes, cordic angle table; no dependencies
package npvc_pkg;
  localparam int CW = 24;
  localparam int DW = 2 * CW + 1;
  localparam logic [DW-1:0] MAX_DIST_SQ = DW'(64'(9999 * 256) * 64'(9999 * 256));

  typedef enum logic [2:0] {
    REG_OBS_X   = 3'd0,
    REG_OBS_Z   = 3'd1,
    REG_HEADING = 3'd2,
    REG_VISION  = 3'd3,
    REG_CLOSE   = 3'd4,
    REG_HALF    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] obj_x;
    logic signed [CW-1:0] obj_y;
    logic signed [CW-1:0] obj_z;
    logic                 usable;
    logic                 last_object;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] target_z;
  } out_item_t;

  // queue entry between front and back
  typedef enum logic [1:0] {
    CMD_HIT  = 2'd0,
    CMD_MISS = 2'd1,
    CMD_YAW  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ROT  = 2'd1,
    BK_OUT  = 2'd2
  } bk_state_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

// ----- src/npvc_front.sv -----
// front part: distance test and nearest tracking, one item per cycle while the job output is not stalled
// depends on npvc_pkg
module npvc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  npvc_pkg::in_item_t          in_data,
  input  logic signed [npvc_pkg::CW-1:0] obs_x,
  input  logic signed [npvc_pkg::CW-1:0] obs_z,
  input  logic [npvc_pkg::CW-2:0]     vision,
  input  logic [npvc_pkg::CW-2:0]     close_rng,
  output logic                        job_valid,
  input  logic                        job_ready,
  output npvc_pkg::job_t              job
);
  import npvc_pkg::*;

  // stage 1: offsets and range check, stage 2: squares and compare
  logic                 s1_v_r;
  in_item_t             s1_d_r;
  logic [CW:0]          ax_r, az_r;
  logic                 inrng_r;
  logic                 s2_v_r;
  in_item_t             s2_d_r;
  logic [DW-1:0]        d2_r, vr2_r, cr2_r;
  logic                 ok2_r;

  logic [DW-1:0] best_r;
  logic signed [CW-1:0] bx_r, by_r, bz_r;
  logic have_r, early_r;

  logic signed [CW:0] dx, dz;
  logic [CW:0] axn, azn;
  logic stall;

  assign stall = job_valid && !job_ready;
  assign in_ready = !stall;

  always_comb begin
    dx = {in_data.obj_x[CW-1], in_data.obj_x} - {obs_x[CW-1], obs_x};
    dz = {in_data.obj_z[CW-1], in_data.obj_z} - {obs_z[CW-1], obs_z};
    axn = dx[CW] ? -dx : dx;
    azn = dz[CW] ? -dz : dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
    if (!stall) begin
      s1_d_r  <= in_data;
      ax_r    <= axn;
      az_r    <= azn;
      inrng_r <= (axn <= (CW+1)'(vision)) && (azn <= (CW+1)'(vision));
      s2_d_r  <= s1_d_r;
      d2_r    <= DW'(46'(ax_r[CW-2:0]) * 46'(ax_r[CW-2:0]))
               + DW'(46'(az_r[CW-2:0]) * 46'(az_r[CW-2:0]));
      vr2_r   <= DW'(46'(vision) * 46'(vision));
      cr2_r   <= DW'(46'(close_rng) * 46'(close_rng));
      ok2_r   <= s1_d_r.usable && inrng_r;
    end
  end

  logic better, hit_close;
  always_comb begin
    better    = ok2_r && (d2_r <= vr2_r) && (d2_r < best_r);
    hit_close = better && (d2_r <= cr2_r);
  end

  logic  jv_nxt;
  job_t  j_nxt;
  logic  fire;
  assign fire = s2_v_r && !stall;

  always_comb begin
    jv_nxt = 1'b0;
    j_nxt  = job;
    if (fire && !early_r) begin
      if (hit_close) begin
        jv_nxt = 1'b1;
        j_nxt  = '{cmd: CMD_HIT, x: s2_d_r.obj_x, y: s2_d_r.obj_y, z: s2_d_r.obj_z};
      end else if (s2_d_r.last_object) begin
        jv_nxt = 1'b1;
        if (better)
          j_nxt = '{cmd: CMD_YAW, x: s2_d_r.obj_x, y: s2_d_r.obj_y, z: s2_d_r.obj_z};
        else if (have_r)
          j_nxt = '{cmd: CMD_YAW, x: bx_r, y: by_r, z: bz_r};
        else
          j_nxt = '{cmd: CMD_MISS, x: '0, y: '0, z: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid <= 1'b0;
      best_r    <= MAX_DIST_SQ;
      have_r    <= 1'b0;
      early_r   <= 1'b0;
    end else begin
      if (!stall) job_valid <= jv_nxt;
      if (fire) begin
        if (s2_d_r.last_object) begin
          best_r  <= MAX_DIST_SQ;
          have_r  <= 1'b0;
          early_r <= 1'b0;
        end else if (!early_r && better) begin
          best_r  <= d2_r;
          have_r  <= 1'b1;
          early_r <= hit_close;
        end
      end
    end
    if (fire && !early_r && better && !s2_d_r.last_object) begin
      bx_r <= s2_d_r.obj_x;
      by_r <= s2_d_r.obj_y;
      bz_r <= s2_d_r.obj_z;
    end
    if (!stall) job <= j_nxt;
  end
endmodule

// ----- src/npvc_queue.sv -----
// two-entry queue of jobs between front and back
// depends on npvc_pkg
module npvc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  npvc_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output npvc_pkg::job_t rd_data
);
  import npvc_pkg::*;
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- src/npvc_back.sv -----
// back part: cordic yaw and view cone test, holds the output register
// depends on npvc_pkg
module npvc_back #(
  parameter int STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  npvc_pkg::job_t              job,
  input  logic signed [npvc_pkg::CW-1:0] obs_x,
  input  logic signed [npvc_pkg::CW-1:0] obs_z,
  input  logic [15:0]                 heading,
  input  logic [15:0]                 half,
  output logic                        out_valid,
  input  logic                        out_ready,
  output npvc_pkg::out_item_t         out_data
);
  import npvc_pkg::*;
  localparam int EW = CW + 4;

  bk_state_t st_r, st_nxt;
  logic signed [EW-1:0] ex_r, ey_r, ex_nxt, ey_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [4:0] i_r, i_nxt;
  job_t hold_r, hold_nxt;
  logic ov_nxt;
  out_item_t od_nxt;

  logic signed [EW-1:0] tx, tz;
  logic [15:0] yaw, off;
  logic hit;

  always_comb begin
    tx = EW'(job.x) - EW'(obs_x);
    tz = EW'(job.z) - EW'(obs_z);
    yaw = 16'((acc_r + 32'h8000) >> 16);
    off = yaw - heading + half;
    hit = (half >= 16'h8000) || ({1'b0, off} <= {half, 1'b0});
  end

  always_comb begin
    st_nxt = st_r; ex_nxt = ex_r; ey_nxt = ey_r; acc_nxt = acc_r;
    i_nxt = i_r; hold_nxt = hold_r; ov_nxt = out_valid; od_nxt = out_data;
    job_ready = 1'b0;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          hold_nxt = job;
          unique case (job.cmd)
            CMD_YAW: begin
              st_nxt = BK_ROT; i_nxt = '0;
              if (tz < 0) begin
                ex_nxt = -tz; ey_nxt = -tx; acc_nxt = 32'h8000_0000;
              end else begin
                ex_nxt = tz; ey_nxt = tx; acc_nxt = '0;
              end
            end
            default: st_nxt = BK_OUT;
          endcase
        end
      end
      BK_ROT: begin
        if (ey_r >= 0) begin
          ex_nxt = ex_r + (ey_r >>> i_r);
          ey_nxt = ey_r - (ex_r >>> i_r);
          acc_nxt = acc_r + atan_turn(i_r);
        end else begin
          ex_nxt = ex_r - (ey_r >>> i_r);
          ey_nxt = ey_r + (ex_r >>> i_r);
          acc_nxt = acc_r - atan_turn(i_r);
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(STEPS - 1)) st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid || out_ready) begin
          ov_nxt = 1'b1;
          st_nxt = BK_IDLE;
          if (hold_r.cmd == CMD_HIT || (hold_r.cmd == CMD_YAW && hit))
            od_nxt = '{found: 1'b1, target_x: hold_r.x, target_y: hold_r.y,
                       target_z: hold_r.z};
          else
            od_nxt = '{found: 1'b0, target_x: '0, target_y: '0, target_z: '0};
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; out_valid <= ov_nxt;
    end
    ex_r <= ex_nxt; ey_r <= ey_nxt; acc_r <= acc_nxt; i_r <= i_nxt;
    hold_r <= hold_nxt; out_data <= od_nxt;
  end
endmodule

// ----- src/nearest_point_view_cone_select.sv -----
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_ready | in_data (in_item_t)
// out     | out | out_valid/out_ready | out_data (out_item_t)
// cfg     | in  | cfg_we            | cfg_index, cfg_wdata
// front takes one item a cycle while the job queue has room; each item is classified
// in a registered pipeline; a list end needing yaw is loaded in the back idle state,
// rotated in the CORDIC rotate state and registered to the output in the out state
// a two-entry job queue lets the front keep streaming while the back works, until it fills
// synchronous active-low reset clears the control state and sets the config registers to zero
module nearest_point_view_cone_select #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  npvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output npvc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import npvc_pkg::*;

  logic signed [CW-1:0] obs_x_r, obs_z_r;
  logic [15:0] heading_r, half_r;
  logic [CW-2:0] vision_r, close_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_x_r <= '0; obs_z_r <= '0; heading_r <= '0;
      half_r <= '0; vision_r <= '0; close_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OBS_X:   obs_x_r   <= cfg_wdata;
        REG_OBS_Z:   obs_z_r   <= cfg_wdata;
        REG_HEADING: heading_r <= cfg_wdata[15:0];
        REG_VISION:  vision_r  <= cfg_wdata[CW-2:0];
        REG_CLOSE:   close_r   <= cfg_wdata[CW-2:0];
        REG_HALF:    half_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic fj_v, fj_r, bj_v, bj_r;
  job_t fj, bj;

  npvc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .obs_x(obs_x_r), .obs_z(obs_z_r), .vision(vision_r), .close_rng(close_r),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj)
  );

  npvc_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_v), .wr_ready(fj_r), .wr_data(fj),
    .rd_valid(bj_v), .rd_ready(bj_r), .rd_data(bj)
  );

  npvc_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job_valid(bj_v), .job_ready(bj_r), .job(bj),
    .obs_x(obs_x_r), .obs_z(obs_z_r), .heading(heading_r), .half(half_r),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- src/npvc_checker.sv -----
// port-level checker for the nearest point view cone select block
// depends on npvc_pkg and the assertion macro header
`include "nearest_point_view_cone_select_assert.svh"
module npvc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input npvc_pkg::out_item_t out_data
);
  import npvc_pkg::*;
  `NPVC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "out beat changed while stalled")
  `NPVC_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_data.found |-> out_data.target_x == '0 && out_data.target_z == '0, "miss carries nonzero target")
  `NPVC_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid, "out valid after reset")
  `NPVC_ASSERT_RST(a_reset_ready, clk, !rst_n |=> in_ready, "in not ready after reset")
endmodule

bind nearest_point_view_cone_select npvc_checker u_npvc_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);

// ----- bench/nearest_point_view_cone_select_tb.sv -----
// testbench for nearest_point_view_cone_select: directed table then random object lists
// self-checking against an in-bench predictor; depends on npvc_pkg and the block
module nearest_point_view_cone_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npvc_pkg::*;

  localparam int STEPS = 16;
  localparam int WATCHDOG = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  nearest_point_view_cone_select #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // predictor copy of registers and list state
  logic signed [23:0] obs_x, obs_z;
  logic [15:0] heading, half_angle;
  logic [22:0] vis_range, near_range;
  logic [63:0] best_d2;
  in_item_t best_obj;
  bit have_cand, done_early;

  out_item_t expected_q[$];
  int mismatches;
  int idle_pct;
  int stall_cycles;

  function automatic logic [31:0] atan_step(int i);
    logic [31:0] tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic logic [15:0] yaw_of(longint ex, longint ey);
    logic [31:0] acc;
    longint nx, ny;
    acc = '0;
    if (ex < 0) begin
      ex = -ex;
      ey = -ey;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (ey >= 0) begin
        nx = ex + (ey >>> i);
        ny = ey - (ex >>> i);
        acc += atan_step(i);
      end else begin
        nx = ex - (ey >>> i);
        ny = ey + (ex >>> i);
        acc -= atan_step(i);
      end
      ex = nx;
      ey = ny;
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function automatic void clear_list();
    best_d2 = 64'(9999 * 256) * 64'(9999 * 256);
    best_obj = '0;
    have_cand = 0;
    done_early = 0;
  endfunction

  function automatic out_item_t target_of(bit hit);
    out_item_t r;
    r = '0;
    if (hit) begin
      r.found = 1;
      r.target_x = best_obj.obj_x;
      r.target_y = best_obj.obj_y;
      r.target_z = best_obj.obj_z;
    end
    return r;
  endfunction

  function automatic void predict_selection(in_item_t it);
    longint dx, dz, ax, az, vr;
    logic [63:0] d2;
    logic [15:0] yaw, off;
    bit hit;
    if (done_early) begin
      if (it.last_object) clear_list();
      return;
    end
    if (it.usable) begin
      dx = longint'(it.obj_x) - longint'(obs_x);
      dz = longint'(it.obj_z) - longint'(obs_z);
      ax = dx < 0 ? -dx : dx;
      az = dz < 0 ? -dz : dz;
      vr = longint'(vis_range);
      if (ax <= vr && az <= vr) begin
        d2 = ax * ax + az * az;
        if (d2 <= vr * vr && d2 < best_d2) begin
          best_d2 = d2;
          best_obj = it;
          have_cand = 1;
          if (d2 <= 64'(near_range) * 64'(near_range)) begin
            expected_q.push_back(target_of(1));
            if (it.last_object) clear_list();
            else done_early = 1;
            return;
          end
        end
      end
    end
    if (!it.last_object) return;
    if (!have_cand) begin
      expected_q.push_back(target_of(0));
    end else begin
      yaw = yaw_of(longint'(best_obj.obj_z) - longint'(obs_z),
                   longint'(best_obj.obj_x) - longint'(obs_x));
      if (half_angle >= 16'd32768) begin
        hit = 1;
      end else begin
        off = yaw - heading + half_angle;
        hit = 17'(off) <= 17'(half_angle) * 2;
      end
      expected_q.push_back(target_of(hit));
    end
    clear_list();
  endfunction

  // write enable stays high across back to back writes, set_view drops it
  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_OBS_X:   obs_x = val;
      REG_OBS_Z:   obs_z = val;
      REG_HEADING: heading = val[15:0];
      REG_VISION:  vis_range = val[22:0];
      REG_CLOSE:   near_range = val[22:0];
      REG_HALF:    half_angle = val[15:0];
      default: ;
    endcase
  endtask

  // wait out outstanding results plus the back-end latency
  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (STEPS + 10) @(posedge clk);
  endtask

  // valid stays high between beats unless an idle gap is drawn
  task automatic send_item(in_item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_selection(it);
  endtask

  task automatic set_view(logic [23:0] ox, logic [23:0] oz, logic [15:0] hd,
                          logic [22:0] vr, logic [22:0] cr, logic [15:0] ha);
    drain();
    write_reg(REG_OBS_X, ox);
    write_reg(REG_OBS_Z, oz);
    write_reg(REG_HEADING, 24'(hd));
    write_reg(REG_VISION, 24'(vr));
    write_reg(REG_CLOSE, 24'(cr));
    write_reg(REG_HALF, 24'(ha));
    cfg_we <= 0;
  endtask

  function automatic in_item_t mk(int x, int y, int z, bit u, bit l);
    in_item_t it;
    it.obj_x = 24'(x);
    it.obj_y = 24'(y);
    it.obj_z = 24'(z);
    it.usable = u;
    it.last_object = l;
    return it;
  endfunction

  // result side: random stall and check against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        stall_cycles <= 0;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          if (out_data !== expected_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", expected_q[0], out_data);
          end
          void'(expected_q.pop_front());
        end
      end else if (in_valid && in_ready) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      out_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // directed rows: item, check value typed in where obvious
  typedef struct {
    in_item_t item;
    bit has_check;
    out_item_t check;
  } row_t;

  row_t rows[$];
  int dir_exp_idx;

  initial begin
    int ox, oz, vr, n, len, mode;
    in_item_t it;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    idle_pct = 17;
    stall_cycles = 0;
    obs_x = 0; obs_z = 0; heading = 0; half_angle = 0; vis_range = 0; near_range = 0;
    clear_list();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // after reset: range zero, only an object on the observer is seen
    rows.push_back('{mk(0, 5, 0, 1, 1), 1, '{1'b1, 24'sd0, 24'sd5, 24'sd0}});
    rows.push_back('{mk(1, 0, 0, 1, 1), 1, '{1'b0, 24'sd0, 24'sd0, 24'sd0}});
    rows.push_back('{mk(0, 0, 0, 0, 1), 1, '{1'b0, 24'sd0, 24'sd0, 24'sd0}});
    foreach (rows[i]) send_item(rows[i].item);
    drain();

    // wide open view, extremes of coordinates
    set_view(24'h000000, 24'h000000, 16'd0, 23'h7FFFFF, 23'd0, 16'd32768);
    send_item(mk(-8388608, -8388608, 8388607, 1, 0));
    send_item(mk(8388607, 8388607, -8388608, 1, 0));
    send_item(mk(256, -1, 256, 1, 1));
    send_item(mk(1000, 0, 0, 1, 0));
    send_item(mk(-1000, 0, 0, 1, 0));      // tie: first kept
    send_item(mk(0, 0, 0, 0, 1));
    // zero view: only yaw == heading passes
    set_view(24'h800000, 24'h7FFFFF, 16'hFFFF, 23'd5000, 23'd10, 16'd0);
    send_item(mk(-8388608, 3, 8388607 - 3000, 1, 1));
    send_item(mk(-8388608 + 2000, 3, 8388607, 1, 1));
    // close hit then ignored rest
    send_item(mk(-8388608 + 5, 0, 8388607, 1, 0));
    send_item(mk(-8388608, 0, 8388607, 1, 0));
    send_item(mk(-8388608, 0, 8388607, 1, 1));
    // cone around heading with wrap
    set_view(24'd100, -24'sd100, 16'd65000, 23'd100000, 23'd50, 16'd2000);
    send_item(mk(100, 0, 5000, 1, 1));
    send_item(mk(100 - 300, 0, 5000, 1, 1));
    send_item(mk(100 + 300, 0, 5000, 1, 1));
    send_item(mk(100, 0, -5000, 1, 1));
    send_item(mk(100, 0, -100, 1, 0));     // on observer, early answer
    send_item(mk(0, 0, 0, 1, 1));
    drain();

    // random lists; one long stretch without idling
    for (int blk = 0; blk < 14; blk++) begin
      idle_pct = (blk == 6 || blk == 7) ? 0 : 17;
      ox = $urandom_range(1) ? $signed($urandom) >>> 8 : int'($urandom_range(4000)) - 2000;
      oz = $urandom_range(1) ? $signed($urandom) >>> 8 : int'($urandom_range(4000)) - 2000;
      vr = $urandom_range(3) == 0 ? int'($urandom & 32'h7FFFFF) : int'($urandom_range(60000));
      set_view(24'(ox), 24'(oz), 16'($urandom), 23'(vr),
               23'($urandom_range(3) == 0 ? $urandom : $urandom_range(vr / 4)),
               16'($urandom_range(4) == 0 ? 32768 + $urandom_range(32767)
                                          : $urandom_range(16000)));
      n = 0;
      while (n < 100) begin
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++) begin
          mode = $urandom_range(9);
          it = mk($urandom, $urandom, $urandom, $urandom_range(9) != 0, k == len - 1);
          if (mode < 8) begin
            it.obj_x = 24'(ox + $signed($urandom_range(2 * vr + 2)) - vr - 1);
            it.obj_z = 24'(oz + $signed($urandom_range(2 * vr + 2)) - vr - 1);
          end
          if (mode == 0) begin
            it.obj_x = 24'(ox);
            it.obj_z = 24'(oz);
          end
          if ($urandom_range(19) == 0) it.last_object = $urandom_range(1);
          send_item(it);
          n++;
        end
      end
    end
    idle_pct = 17;
    drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // directed rows with typed values are checked here against the check values typed in each row
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && dir_exp_idx < rows.size()) begin
      while (dir_exp_idx < rows.size() && !rows[dir_exp_idx].has_check) dir_exp_idx++;
      if (dir_exp_idx < rows.size()) begin
        if (out_data !== rows[dir_exp_idx].check) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %p got %p", dir_exp_idx,
                     rows[dir_exp_idx].check, out_data);
        end
        dir_exp_idx++;
      end
    end
  end

  initial dir_exp_idx = 0;
endmodule
